>>> src/srmc_pkg.sv
// ----------------------------------------------------------------------------
// srmc_pkg
// Shared types, codes, relay tables and lookup functions of the serial relay
// matrix controller.
// ----------------------------------------------------------------------------
package srmc_pkg;

  localparam int INIT_LEN_DEF    = 32;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int IDX_W           = 6;
  localparam int MAP_LEN         = 68;
  localparam int INIT_SLOTS      = 64;

  localparam logic [7:0] MARK_HEAD   = 8'h55;
  localparam logic [7:0] MARK_END    = 8'h56;
  localparam logic [7:0] MARK_SKIP   = 8'h57;
  localparam logic [7:0] MARK_REPLAY = 8'h58;
  localparam logic [7:0] NO_RELAY    = 8'hFF;
  localparam logic [7:0] PORT_IDLE   = 8'hFF;

  localparam logic [7:0] ROUTE_FRAME = 8'h73;
  localparam logic [7:0] ROUTE_FWD   = 8'h6E;
  localparam logic [7:0] ROUTE_RAW   = 8'h74;

  localparam logic [7:0] PULSE_RST   = 8'h1F;
  localparam logic [7:0] RELEASE_RST = 8'h03;

  localparam logic CFG_PULSE   = 1'b0;
  localparam logic CFG_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    OP_HOST  = 2'd0,
    OP_AUX   = 2'd1,
    OP_START = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    DEST_HOST  = 2'd0,
    DEST_AUX   = 2'd1,
    DEST_DRIVE = 2'd2
  } dest_e;

  typedef enum logic [2:0] {
    PM_IDLE   = 3'd0,
    PM_MARK   = 3'd1,
    PM_FRAME  = 3'd2,
    PM_RAWROW = 3'd3,
    PM_RAWCOL = 3'd4
  } parse_e;

  typedef enum logic [2:0] {
    JOB_HOST   = 3'd0,
    JOB_AUX    = 3'd1,
    JOB_SEQ    = 3'd2,
    JOB_RELAY  = 3'd3,
    JOB_REPLY  = 3'd4,
    JOB_RAWROW = 3'd5,
    JOB_RAWCOL = 3'd6
  } job_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } back_e;

  typedef struct packed {
    job_e       kind;
    logic [7:0] b0;
    logic [7:0] b1;
  } job_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] num;
  } relay_t;

  localparam logic [7:0] RELAY_MAP [MAP_LEN] = '{
    8'd43, 8'd47, 8'd31, 8'd255, 8'd19, 8'd17, 8'd23, 8'd21,
    8'd46, 8'd42, 8'd255, 8'd30, 8'd16, 8'd18, 8'd20, 8'd22,
    8'd41, 8'd57, 8'd45, 8'd53, 8'd0, 8'd255, 8'd2, 8'd54,
    8'd56, 8'd40, 8'd52, 8'd44, 8'd255, 8'd1, 8'd55, 8'd3,
    8'd4, 8'd27, 8'd63, 8'd6, 8'd35, 8'd33, 8'd39, 8'd37,
    8'd26, 8'd5, 8'd7, 8'd62, 8'd32, 8'd34, 8'd36, 8'd38,
    8'd61, 8'd59, 8'd25, 8'd29, 8'd9, 8'd11, 8'd13, 8'd15,
    8'd58, 8'd60, 8'd28, 8'd24, 8'd10, 8'd8, 8'd14, 8'd12,
    8'd49, 8'd48, 8'd51, 8'd50
  };

  localparam logic [7:0] INIT_LIST [INIT_SLOTS] = '{
    8'h26, 8'h27, 8'h0F, 8'h3E, 8'h3F, 8'h3C, 8'h34, 8'h0D,
    8'h0C, 8'h0E, 8'h2D, 8'h14, 8'h0B, 8'h33, 8'h21, 8'h32,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
  };

  function automatic relay_t map_code(logic [7:0] code);
    relay_t     r;
    logic [7:0] n;
    n = NO_RELAY;
    if (code < 8'(MAP_LEN)) begin
      n = RELAY_MAP[code[6:0]];
    end
    r.hit = (n != NO_RELAY);
    r.num = n[5:0];
    return r;
  endfunction

  function automatic relay_t init_relay(logic [IDX_W-1:0] idx);
    return map_code(INIT_LIST[idx]);
  endfunction

  function automatic logic [7:0] one_low(logic [2:0] pos);
    return ~(8'h80 >> pos);
  endfunction

  // index of the last mapped init slot below len, -1 if none
  function automatic int seq_last(int len);
    int last;
    last = -1;
    for (int i = 0; i < INIT_SLOTS; i++) begin
      if (i < len && init_relay(IDX_W'(i)).hit) begin
        last = i;
      end
    end
    return last;
  endfunction

endpackage

>>> src/serial_relay_matrix_controller.sv
// ----------------------------------------------------------------------------
// serial_relay_matrix_controller
// Host/aux byte router and relay matrix driver: a parser front end feeds a
// job queue; a sequencer back end gives one result per cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  in       | input     | in_valid_i/in_stall_o | op, data, status_a, status_b
//  out      | output    | out_valid_o/out_stall_i | dest, out_byte, row/col drive,
//           |           |                       | hold, last
//  cfg      | input     | cfg_we_i              | cfg_idx_i, cfg_data_i
//
//  a transaction is parsed in the cycle it is taken; a job waits in the queue
//  the sequencer takes a job while idle, then one result per cycle unless stalled
//  start-up: empty init slots give nothing, mapped slots a pulse and a release
//  in_stall_o is high while the QUEUE_DEPTH-entry job queue is full
//  reset clears parse state, port levels, queue and config to defaults
// ----------------------------------------------------------------------------
module serial_relay_matrix_controller #(
  parameter int INIT_LEN    = srmc_pkg::INIT_LEN_DEF,
  parameter int QUEUE_DEPTH = srmc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic [7:0] data_i,
  input  logic [7:0] status_a_i,
  input  logic [7:0] status_b_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] dest_o,
  output logic [7:0] out_byte_o,
  output logic [7:0] row_drive_o,
  output logic [7:0] col_drive_o,
  output logic [7:0] hold_o,
  output logic       last_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  logic           accept, push, pop, full, empty;
  srmc_pkg::job_t job_in, job_out;

  assign in_stall_o = full;
  assign accept     = in_valid_i & ~full;

  srmc_front #(
    .INIT_LEN(INIT_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .op_i       (op_i),
    .data_i     (data_i),
    .status_a_i (status_a_i),
    .status_b_i (status_b_i),
    .push_o     (push),
    .job_o      (job_in)
  );

  srmc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .data_o  (job_out),
    .full_o  (full),
    .empty_o (empty)
  );

  srmc_back #(
    .INIT_LEN(INIT_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .job_i       (job_out),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dest_o      (dest_o),
    .out_byte_o  (out_byte_o),
    .row_drive_o (row_drive_o),
    .col_drive_o (col_drive_o),
    .hold_o      (hold_o),
    .last_o      (last_o)
  );

endmodule

>>> src/srmc_front.sv
// ----------------------------------------------------------------------------
// srmc_front
// Host byte parser: tracks mark escapes, routing mode and port levels, and
// turns each transaction into at most one job for the back end.
// ----------------------------------------------------------------------------
module srmc_front #(
  parameter int INIT_LEN = srmc_pkg::INIT_LEN_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [1:0]          op_i,
  input  logic [7:0]          data_i,
  input  logic [7:0]          status_a_i,
  input  logic [7:0]          status_b_i,
  output logic                push_o,
  output srmc_pkg::job_t      job_o
);

  localparam int  SEQ_N   = INIT_LEN & 63;
  localparam logic SEQ_ANY = (srmc_pkg::seq_last(SEQ_N) >= 0);

  srmc_pkg::parse_e mode_q, mode_d;
  logic [7:0]       route_q, route_d;
  logic [7:0]       row_q, row_d;
  logic [7:0]       col_q, col_d;
  logic             route_lit;
  srmc_pkg::relay_t rel;

  always_comb begin
    mode_d    = mode_q;
    route_d   = route_q;
    row_d     = row_q;
    col_d     = col_q;
    route_lit = 1'b0;
    push_o    = 1'b0;
    job_o     = '{kind: srmc_pkg::JOB_HOST, b0: data_i, b1: 8'h00};
    rel       = srmc_pkg::map_code(data_i);
    if (accept_i) begin
      unique case (op_i)
        srmc_pkg::OP_AUX: begin
          push_o = 1'b1;
        end
        srmc_pkg::OP_START: begin
          if (SEQ_ANY) begin
            push_o     = 1'b1;
            job_o.kind = srmc_pkg::JOB_SEQ;
            row_d      = srmc_pkg::PORT_IDLE;
            col_d      = srmc_pkg::PORT_IDLE;
          end
        end
        srmc_pkg::OP_HOST: begin
          case (mode_q)
            srmc_pkg::PM_MARK: begin
              mode_d = srmc_pkg::PM_IDLE;
              if (data_i != srmc_pkg::MARK_HEAD) begin
                route_d = data_i;
              end else begin
                route_lit = 1'b1;
              end
            end
            srmc_pkg::PM_FRAME: begin
              if (data_i == srmc_pkg::MARK_END) begin
                mode_d = srmc_pkg::PM_IDLE;
                push_o = 1'b1;
                job_o  = '{kind: srmc_pkg::JOB_REPLY, b0: status_a_i, b1: status_b_i};
              end else if (data_i == srmc_pkg::MARK_REPLAY) begin
                if (SEQ_ANY) begin
                  push_o     = 1'b1;
                  job_o.kind = srmc_pkg::JOB_SEQ;
                  row_d      = srmc_pkg::PORT_IDLE;
                  col_d      = srmc_pkg::PORT_IDLE;
                end
              end else if (data_i != srmc_pkg::MARK_SKIP && rel.hit) begin
                push_o = 1'b1;
                job_o  = '{kind: srmc_pkg::JOB_RELAY, b0: {2'b00, rel.num}, b1: 8'h00};
                row_d  = srmc_pkg::PORT_IDLE;
                col_d  = srmc_pkg::PORT_IDLE;
              end
            end
            srmc_pkg::PM_RAWROW: begin
              row_d  = data_i;
              mode_d = srmc_pkg::PM_RAWCOL;
              push_o = 1'b1;
              job_o  = '{kind: srmc_pkg::JOB_RAWROW, b0: data_i, b1: col_q};
            end
            srmc_pkg::PM_RAWCOL: begin
              col_d  = data_i;
              mode_d = srmc_pkg::PM_IDLE;
              push_o = 1'b1;
              job_o  = '{kind: srmc_pkg::JOB_RAWCOL, b0: row_q, b1: data_i};
            end
            default: begin
              mode_d = srmc_pkg::PM_IDLE;
              if (data_i == srmc_pkg::MARK_HEAD) begin
                mode_d = srmc_pkg::PM_MARK;
              end else begin
                route_lit = 1'b1;
              end
            end
          endcase
          if (route_lit) begin
            case (route_q)
              srmc_pkg::ROUTE_FRAME: begin
                if (data_i == srmc_pkg::MARK_HEAD) begin
                  mode_d = srmc_pkg::PM_FRAME;
                end
              end
              srmc_pkg::ROUTE_FWD: begin
                push_o     = 1'b1;
                job_o.kind = srmc_pkg::JOB_AUX;
              end
              srmc_pkg::ROUTE_RAW: begin
                mode_d = srmc_pkg::PM_RAWROW;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= srmc_pkg::PM_IDLE;
      route_q <= 8'h00;
      row_q   <= srmc_pkg::PORT_IDLE;
      col_q   <= srmc_pkg::PORT_IDLE;
    end else begin
      mode_q  <= mode_d;
      route_q <= route_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

endmodule

>>> src/srmc_queue.sv
// ----------------------------------------------------------------------------
// srmc_queue
// Small job FIFO between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module srmc_queue #(
  parameter int DEPTH = srmc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  srmc_pkg::job_t data_i,
  input  logic           pop_i,
  output srmc_pkg::job_t data_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  srmc_pkg::job_t mem_q [DEPTH];
  logic [AW-1:0]  wr_q, wr_d;
  logic [AW-1:0]  rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

>>> src/srmc_back.sv
// ----------------------------------------------------------------------------
// srmc_back
// Result sequencer: expands one job into host bytes, aux bytes and relay
// drive steps, one result per cycle into the output register unless stalled.
// ----------------------------------------------------------------------------
module srmc_back #(
  parameter int INIT_LEN = srmc_pkg::INIT_LEN_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [7:0]     cfg_data_i,
  input  srmc_pkg::job_t job_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [1:0]     dest_o,
  output logic [7:0]     out_byte_o,
  output logic [7:0]     row_drive_o,
  output logic [7:0]     col_drive_o,
  output logic [7:0]     hold_o,
  output logic           last_o
);

  localparam int SEQ_N = INIT_LEN & 63;
  localparam logic [srmc_pkg::IDX_W-1:0] SEQ_END = srmc_pkg::IDX_W'(SEQ_N - 1);
  localparam logic [srmc_pkg::IDX_W-1:0] SEQ_FIN = srmc_pkg::IDX_W'(srmc_pkg::seq_last(SEQ_N));

  srmc_pkg::back_e               state_q, state_d;
  srmc_pkg::job_t                job_q;
  logic [1:0]                    step_q, step_d;
  logic [srmc_pkg::IDX_W-1:0]    idx_q, idx_d;
  logic [7:0]                    pulse_q, release_q;
  logic                          valid_q, valid_d;
  srmc_pkg::dest_e               dest_q, r_dest;
  logic [7:0]                    byte_q, r_byte;
  logic [7:0]                    row_q, r_row;
  logic [7:0]                    col_q, r_col;
  logic [7:0]                    hold_q, r_hold;
  logic                          last_q, r_last;
  logic                          slot_free, emit, done;
  srmc_pkg::relay_t              ent;
  logic [5:0]                    num;

  assign slot_free = ~valid_q | ~out_stall_i;
  assign pop_o     = (state_q == srmc_pkg::BK_IDLE) & ~empty_i;
  assign ent       = srmc_pkg::init_relay(idx_q);
  assign num       = (job_q.kind == srmc_pkg::JOB_SEQ) ? ent.num : job_q.b0[5:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srmc_pkg::BK_IDLE: if (!empty_i) state_d = srmc_pkg::BK_RUN;
      srmc_pkg::BK_RUN:  if (slot_free && done) state_d = srmc_pkg::BK_IDLE;
      default:           state_d = srmc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    emit   = 1'b0;
    done   = 1'b0;
    r_dest = srmc_pkg::DEST_HOST;
    r_byte = 8'h00;
    r_row  = 8'h00;
    r_col  = 8'h00;
    r_hold = 8'h00;
    r_last = 1'b0;
    step_d = step_q;
    idx_d  = idx_q;
    if (state_q == srmc_pkg::BK_RUN && slot_free) begin
      case (job_q.kind)
        srmc_pkg::JOB_HOST, srmc_pkg::JOB_AUX: begin
          emit   = 1'b1;
          r_dest = (job_q.kind == srmc_pkg::JOB_AUX) ? srmc_pkg::DEST_AUX : srmc_pkg::DEST_HOST;
          r_byte = job_q.b0;
          r_last = 1'b1;
          done   = 1'b1;
        end
        srmc_pkg::JOB_RELAY, srmc_pkg::JOB_SEQ: begin
          if (job_q.kind == srmc_pkg::JOB_SEQ && !ent.hit) begin
            if (idx_q == SEQ_END) begin
              done = 1'b1;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end else begin
            emit   = 1'b1;
            r_dest = srmc_pkg::DEST_DRIVE;
            if (step_q == 2'd0) begin
              r_row  = srmc_pkg::one_low(num[5:3]);
              r_col  = srmc_pkg::one_low(num[2:0]);
              r_hold = pulse_q;
              step_d = 2'd1;
            end else begin
              r_row  = srmc_pkg::PORT_IDLE;
              r_col  = srmc_pkg::PORT_IDLE;
              r_hold = release_q;
              step_d = 2'd0;
              if (job_q.kind == srmc_pkg::JOB_RELAY) begin
                r_last = 1'b1;
                done   = 1'b1;
              end else begin
                r_last = (idx_q == SEQ_FIN);
                if (idx_q == SEQ_END) begin
                  done = 1'b1;
                end else begin
                  idx_d = idx_q + 1'b1;
                end
              end
            end
          end
        end
        srmc_pkg::JOB_REPLY: begin
          emit   = 1'b1;
          step_d = step_q + 1'b1;
          case (step_q)
            2'd0:    r_byte = srmc_pkg::MARK_HEAD;
            2'd1:    r_byte = job_q.b0;
            2'd2:    r_byte = job_q.b1;
            default: begin
              r_byte = srmc_pkg::MARK_END;
              r_last = 1'b1;
              done   = 1'b1;
            end
          endcase
        end
        srmc_pkg::JOB_RAWROW: begin
          emit   = 1'b1;
          r_dest = srmc_pkg::DEST_DRIVE;
          r_row  = job_q.b0;
          r_col  = job_q.b1;
          r_last = 1'b1;
          done   = 1'b1;
        end
        srmc_pkg::JOB_RAWCOL: begin
          emit = 1'b1;
          if (step_q == 2'd0) begin
            r_dest = srmc_pkg::DEST_DRIVE;
            r_row  = job_q.b0;
            r_col  = job_q.b1;
            step_d = 2'd1;
          end else begin
            r_byte = srmc_pkg::MARK_END;
            r_last = 1'b1;
            done   = 1'b1;
          end
        end
        default: done = 1'b1;
      endcase
    end
  end

  assign valid_d = emit | (valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= srmc_pkg::BK_IDLE;
      step_q    <= 2'd0;
      idx_q     <= '0;
      valid_q   <= 1'b0;
      pulse_q   <= srmc_pkg::PULSE_RST;
      release_q <= srmc_pkg::RELEASE_RST;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      if (pop_o) begin
        step_q <= 2'd0;
        idx_q  <= '0;
      end else begin
        step_q <= step_d;
        idx_q  <= idx_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          srmc_pkg::CFG_PULSE:   pulse_q   <= cfg_data_i;
          srmc_pkg::CFG_RELEASE: release_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (emit) begin
      dest_q <= r_dest;
      byte_q <= r_byte;
      row_q  <= r_row;
      col_q  <= r_col;
      hold_q <= r_hold;
      last_q <= r_last;
    end
  end

  assign out_valid_o = valid_q;
  assign dest_o      = dest_q;
  assign out_byte_o  = byte_q;
  assign row_drive_o = row_q;
  assign col_drive_o = col_q;
  assign hold_o      = hold_q;
  assign last_o      = last_q;

endmodule

>>> src/srmc_checker.sv
// ----------------------------------------------------------------------------
// srmc_checker
// Port-level checks of the serial relay matrix controller, bound to the top.
// ----------------------------------------------------------------------------
module srmc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] dest_o,
  input logic [7:0] out_byte_o,
  input logic [7:0] row_drive_o,
  input logic [7:0] col_drive_o,
  input logic [7:0] hold_o,
  input logic       last_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable({dest_o, out_byte_o, row_drive_o, col_drive_o, hold_o, last_o}))
    else $error("stalled result changed");

  // byte results carry no drive
  a_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dest_o != srmc_pkg::DEST_DRIVE |->
      row_drive_o == 8'h00 && col_drive_o == 8'h00 && hold_o == 8'h00 &&
      (dest_o == srmc_pkg::DEST_HOST || dest_o == srmc_pkg::DEST_AUX))
    else $error("byte result with drive fields set");

  // drive results carry no byte
  a_drive_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dest_o == srmc_pkg::DEST_DRIVE |-> out_byte_o == 8'h00)
    else $error("drive result with byte set");

  // timed drives are one-hot pulses or full release
  a_timed_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dest_o == srmc_pkg::DEST_DRIVE && hold_o != 8'h00 |->
      (row_drive_o == 8'hFF && col_drive_o == 8'hFF) ||
      ($onehot(~row_drive_o) && $onehot(~col_drive_o)))
    else $error("timed drive is not a pulse or release");

endmodule

bind serial_relay_matrix_controller srmc_checker u_srmc_checker (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Sends host, aux and start-up transactions into the relay matrix controller
// and compares every result with a predictor of its parser and relay
// sequencer, across register settings and idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          CODE_COUNT     = 68;
  localparam int          SEQ_LEN        = 32;
  localparam int          DRAIN_CYCLES   = 24;
  localparam int          HOLDOFF_CYCLES = 300;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          ITEMS_PER_PASS = 50;
  localparam logic [1:0]  OP_NONE        = 2'd3;
  localparam logic [7:0]  ROUTE_OTHER    = 8'h71;

  localparam logic [7:0] RELAY_TAB [CODE_COUNT] = '{
    8'd43, 8'd47, 8'd31, 8'd255, 8'd19, 8'd17, 8'd23, 8'd21,
    8'd46, 8'd42, 8'd255, 8'd30, 8'd16, 8'd18, 8'd20, 8'd22,
    8'd41, 8'd57, 8'd45, 8'd53, 8'd0, 8'd255, 8'd2, 8'd54,
    8'd56, 8'd40, 8'd52, 8'd44, 8'd255, 8'd1, 8'd55, 8'd3,
    8'd4, 8'd27, 8'd63, 8'd6, 8'd35, 8'd33, 8'd39, 8'd37,
    8'd26, 8'd5, 8'd7, 8'd62, 8'd32, 8'd34, 8'd36, 8'd38,
    8'd61, 8'd59, 8'd25, 8'd29, 8'd9, 8'd11, 8'd13, 8'd15,
    8'd58, 8'd60, 8'd28, 8'd24, 8'd10, 8'd8, 8'd14, 8'd12,
    8'd49, 8'd48, 8'd51, 8'd50
  };

  localparam logic [7:0] START_CODES [16] = '{
    8'h26, 8'h27, 8'h0F, 8'h3E, 8'h3F, 8'h3C, 8'h34, 8'h0D,
    8'h0C, 8'h0E, 8'h2D, 8'h14, 8'h0B, 8'h33, 8'h21, 8'h32
  };

  typedef enum logic [1:0] {
    CHK_MODEL = 2'd0,
    CHK_ONE   = 2'd1,
    CHK_NONE  = 2'd2
  } chk_e;

  typedef struct packed {
    srmc_pkg::dest_e dest;
    logic [7:0]      out_byte;
    logic [7:0]      row;
    logic [7:0]      col;
    logic [7:0]      hold;
    logic            last;
  } result_t;

  typedef struct packed {
    chk_e            chk;
    logic [1:0]      op;
    logic [7:0]      data;
    logic [7:0]      sa;
    logic [7:0]      sb;
    srmc_pkg::dest_e dest;
    logic [7:0]      out_byte;
    logic [7:0]      row;
    logic [7:0]      col;
  } step_t;

  step_t directed_steps [28] = '{
    '{CHK_ONE, srmc_pkg::OP_AUX, 8'h00, 8'h00, 8'h00, srmc_pkg::DEST_HOST,
      8'h00, 8'h00, 8'h00},
    '{CHK_ONE, srmc_pkg::OP_AUX, 8'hFF, 8'hFF, 8'hFF, srmc_pkg::DEST_HOST,
      8'hFF, 8'h00, 8'h00},
    // op 3 is ignored
    '{CHK_NONE, OP_NONE, 8'hA5, 8'h5A, 8'hA5, srmc_pkg::DEST_HOST,
      8'h00, 8'h00, 8'h00},
    '{CHK_NONE, srmc_pkg::OP_HOST, srmc_pkg::MARK_HEAD, 8'h00, 8'h00, srmc_pkg::DEST_HOST,
      8'h00, 8'h00, 8'h00},
    '{CHK_NONE, srmc_pkg::OP_HOST, srmc_pkg::ROUTE_FRAME, 8'h00, 8'h00, srmc_pkg::DEST_HOST,
      8'h00, 8'h00, 8'h00},
    '{CHK_NONE, srmc_pkg::OP_HOST, srmc_pkg::MARK_HEAD, 8'h00, 8'h00, srmc_pkg::DEST_HOST,
      8'h00, 8'h00, 8'h00},
    '{CHK_NONE, srmc_pkg::OP_HOST, srmc_pkg::MARK_HEAD, 8'h00, 8'h00, srmc_pkg::DEST_HOST,
      8'h00, 8'h00, 8'h00},
    '{CHK_MODEL, srmc_pkg::OP_HOST, 8'h00, 8'h00, 8'h00, srmc_pkg::DEST_HOST,
      8'h00, 8'h00, 8'h00},
    '{CHK_MODEL, srmc_pkg::OP_HOST, 8'h43, 8'h00, 8'h00, srmc_pkg::DEST_HOST,
      8'h00, 8'h00, 8'h00},
    // empty table entry, then codes past the table
    '{CHK_NONE, srmc_pkg::OP_HOST, 8'h03, 8'h00, 8'h00, srmc_pkg::DEST_HOST,
      8'h00, 8'h00, 8'h00},
    '{CHK_NONE, srmc_pkg::OP_HOST, 8'h44, 8'h00, 8'h00, srmc_pkg::DEST_HOST,
      8'h00, 8'h00, 8'h00},
    '{CHK_NONE, srmc_pkg::OP_HOST, 8'hFF, 8'h00, 8'h00, srmc_pkg::DEST_HOST,
      8'h00, 8'h00, 8'h00},
    '{CHK_NONE, srmc_pkg::OP_HOST, srmc_pkg::MARK_SKIP, 8'h00, 8'h00, srmc_pkg::DEST_HOST,
      8'h00, 8'h00, 8'h00},
    // aux and start-up inside an open frame
    '{CHK_ONE, srmc_pkg::OP_AUX, 8'h5A, 8'h00, 8'h00, srmc_pkg::DEST_HOST,
      8'h5A, 8'h00, 8'h00},
    '{CHK_MODEL, srmc_pkg::OP_START, 8'h00, 8'h00, 8'h00, srmc_pkg::DEST_HOST,
      8'h00, 8'h00, 8'h00},
    '{CHK_MODEL, srmc_pkg::OP_HOST, srmc_pkg::MARK_REPLAY, 8'h00, 8'h00, srmc_pkg::DEST_HOST,
      8'h00, 8'h00, 8'h00},
    '{CHK_MODEL, srmc_pkg::OP_HOST, srmc_pkg::MARK_END, 8'hFF, 8'h00, srmc_pkg::DEST_HOST,
      8'h00, 8'h00, 8'h00},
    '{CHK_NONE, srmc_pkg::OP_HOST, srmc_pkg::MARK_HEAD, 8'h00, 8'h00, srmc_pkg::DEST_HOST,
      8'h00, 8'h00, 8'h00},
    '{CHK_NONE, srmc_pkg::OP_HOST, srmc_pkg::ROUTE_FWD, 8'h00, 8'h00, srmc_pkg::DEST_HOST,
      8'h00, 8'h00, 8'h00},
    '{CHK_ONE, srmc_pkg::OP_HOST, 8'h00, 8'h00, 8'h00, srmc_pkg::DEST_AUX,
      8'h00, 8'h00, 8'h00},
    '{CHK_NONE, srmc_pkg::OP_HOST, srmc_pkg::MARK_HEAD, 8'h00, 8'h00, srmc_pkg::DEST_HOST,
      8'h00, 8'h00, 8'h00},
    '{CHK_NONE, srmc_pkg::OP_HOST, srmc_pkg::ROUTE_RAW, 8'h00, 8'h00, srmc_pkg::DEST_HOST,
      8'h00, 8'h00, 8'h00},
    '{CHK_NONE, srmc_pkg::OP_HOST, 8'h12, 8'h00, 8'h00, srmc_pkg::DEST_HOST,
      8'h00, 8'h00, 8'h00},
    // raw row write keeps the old column level
    '{CHK_ONE, srmc_pkg::OP_HOST, 8'h00, 8'h00, 8'h00, srmc_pkg::DEST_DRIVE,
      8'h00, 8'h00, 8'hFF},
    '{CHK_MODEL, srmc_pkg::OP_HOST, 8'hFF, 8'h00, 8'h00, srmc_pkg::DEST_HOST,
      8'h00, 8'h00, 8'h00},
    // unknown route mode drops bytes
    '{CHK_NONE, srmc_pkg::OP_HOST, srmc_pkg::MARK_HEAD, 8'h00, 8'h00, srmc_pkg::DEST_HOST,
      8'h00, 8'h00, 8'h00},
    '{CHK_NONE, srmc_pkg::OP_HOST, ROUTE_OTHER, 8'h00, 8'h00, srmc_pkg::DEST_HOST,
      8'h00, 8'h00, 8'h00},
    '{CHK_NONE, srmc_pkg::OP_HOST, 8'h33, 8'h00, 8'h00, srmc_pkg::DEST_HOST,
      8'h00, 8'h00, 8'h00}
  };

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [1:0] op        = 2'd0;
  logic [7:0] data      = 8'h00;
  logic [7:0] status_a  = 8'h00;
  logic [7:0] status_b  = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] dest;
  logic [7:0] out_byte;
  logic [7:0] row_drive;
  logic [7:0] col_drive;
  logic [7:0] hold;
  logic       last;
  logic       cfg_we    = 1'b0;
  logic       cfg_idx   = srmc_pkg::CFG_PULSE;
  logic [7:0] cfg_data  = 8'h00;

  srmc_pkg::parse_e pm_state;
  logic [7:0]       route_mode;
  logic [7:0]       row_level;
  logic [7:0]       col_level;
  logic [7:0]       pulse_ticks;
  logic [7:0]       release_ticks;

  result_t expected_results [$];
  result_t burst [$];
  int      fails        = 0;
  int      items_sent   = 0;
  int      idle_pct     = 0;
  int      stall_pct    = 0;
  int      quiet_cycles = 0;
  bit      holdoff_req  = 1'b0;

  serial_relay_matrix_controller dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .op_i        (op),
    .data_i      (data),
    .status_a_i  (status_a),
    .status_b_i  (status_b),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .dest_o      (dest),
    .out_byte_o  (out_byte),
    .row_drive_o (row_drive),
    .col_drive_o (col_drive),
    .hold_o      (hold),
    .last_o      (last),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void reset_model();
    pm_state      = srmc_pkg::PM_IDLE;
    route_mode    = 8'h00;
    row_level     = srmc_pkg::PORT_IDLE;
    col_level     = srmc_pkg::PORT_IDLE;
    pulse_ticks   = srmc_pkg::PULSE_RST;
    release_ticks = srmc_pkg::RELEASE_RST;
  endfunction

  function automatic void add_result(srmc_pkg::dest_e d, logic [7:0] b, logic [7:0] r,
                                     logic [7:0] c, logic [7:0] h);
    result_t x;
    x.dest     = d;
    x.out_byte = b;
    x.row      = r;
    x.col      = c;
    x.hold     = h;
    x.last     = 1'b0;
    burst.push_back(x);
  endfunction

  function automatic void fire_coil(logic [7:0] code);
    logic [7:0] n;
    if (code >= 8'(CODE_COUNT)) return;
    n = RELAY_TAB[code[6:0]];
    if (n == srmc_pkg::NO_RELAY) return;
    row_level = 8'hFF ^ (8'h80 >> n[5:3]);
    col_level = 8'hFF ^ (8'h80 >> n[2:0]);
    add_result(srmc_pkg::DEST_DRIVE, 8'h00, row_level, col_level, pulse_ticks);
    row_level = srmc_pkg::PORT_IDLE;
    col_level = srmc_pkg::PORT_IDLE;
    add_result(srmc_pkg::DEST_DRIVE, 8'h00, row_level, col_level, release_ticks);
  endfunction

  function automatic void run_start_list();
    for (int i = 0; i < (SEQ_LEN & 63); i++) begin
      if (i < 16) fire_coil(START_CODES[i]);
    end
  endfunction

  function automatic void route_host_byte(logic [7:0] b);
    if (route_mode == srmc_pkg::ROUTE_FRAME) begin
      if (b == srmc_pkg::MARK_HEAD) pm_state = srmc_pkg::PM_FRAME;
    end else if (route_mode == srmc_pkg::ROUTE_FWD) begin
      add_result(srmc_pkg::DEST_AUX, b, 8'h00, 8'h00, 8'h00);
    end else if (route_mode == srmc_pkg::ROUTE_RAW) begin
      pm_state = srmc_pkg::PM_RAWROW;
    end
  endfunction

  function automatic void take_host_byte(logic [7:0] b, logic [7:0] sa, logic [7:0] sb);
    case (pm_state)
      srmc_pkg::PM_MARK: begin
        pm_state = srmc_pkg::PM_IDLE;
        if (b != srmc_pkg::MARK_HEAD) route_mode = b;
        else route_host_byte(b);
      end
      srmc_pkg::PM_FRAME: begin
        if (b == srmc_pkg::MARK_END) begin
          pm_state = srmc_pkg::PM_IDLE;
          add_result(srmc_pkg::DEST_HOST, srmc_pkg::MARK_HEAD, 8'h00, 8'h00, 8'h00);
          add_result(srmc_pkg::DEST_HOST, sa, 8'h00, 8'h00, 8'h00);
          add_result(srmc_pkg::DEST_HOST, sb, 8'h00, 8'h00, 8'h00);
          add_result(srmc_pkg::DEST_HOST, srmc_pkg::MARK_END, 8'h00, 8'h00, 8'h00);
        end else if (b == srmc_pkg::MARK_REPLAY) begin
          run_start_list();
        end else if (b != srmc_pkg::MARK_SKIP) begin
          fire_coil(b);
        end
      end
      srmc_pkg::PM_RAWROW: begin
        row_level = b;
        add_result(srmc_pkg::DEST_DRIVE, 8'h00, row_level, col_level, 8'h00);
        pm_state = srmc_pkg::PM_RAWCOL;
      end
      srmc_pkg::PM_RAWCOL: begin
        col_level = b;
        add_result(srmc_pkg::DEST_DRIVE, 8'h00, row_level, col_level, 8'h00);
        add_result(srmc_pkg::DEST_HOST, srmc_pkg::MARK_END, 8'h00, 8'h00, 8'h00);
        pm_state = srmc_pkg::PM_IDLE;
      end
      default: begin
        pm_state = srmc_pkg::PM_IDLE;
        if (b == srmc_pkg::MARK_HEAD) pm_state = srmc_pkg::PM_MARK;
        else route_host_byte(b);
      end
    endcase
  endfunction

  function automatic void predict_transaction(logic [1:0] op_v, logic [7:0] b,
                                              logic [7:0] sa, logic [7:0] sb);
    result_t tail;
    burst.delete();
    case (op_v)
      srmc_pkg::OP_HOST:  take_host_byte(b, sa, sb);
      srmc_pkg::OP_AUX:   add_result(srmc_pkg::DEST_HOST, b, 8'h00, 8'h00, 8'h00);
      srmc_pkg::OP_START: run_start_list();
      default: ;
    endcase
    if (burst.size() > 0) begin
      tail = burst.pop_back();
      tail.last = 1'b1;
      burst.push_back(tail);
    end
  endfunction

  task automatic send(logic [1:0] op_v, logic [7:0] b, logic [7:0] sa, logic [7:0] sb,
                      bit from_model);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op       <= op_v;
    data     <= b;
    status_a <= sa;
    status_b <= sb;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_transaction(op_v, b, sa, sb);
    if (from_model) begin
      foreach (burst[i]) expected_results.push_back(burst[i]);
    end
    if (op_v != OP_NONE) items_sent++;
  endtask

  task automatic host(logic [7:0] b);
    send(srmc_pkg::OP_HOST, b, 8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_registers(logic [7:0] pulse_v, logic [7:0] release_v);
    cfg_we   <= 1'b1;
    cfg_idx  <= srmc_pkg::CFG_PULSE;
    cfg_data <= pulse_v;
    pulse_ticks = pulse_v;
    @(posedge clk);
    cfg_idx  <= srmc_pkg::CFG_RELEASE;
    cfg_data <= release_v;
    release_ticks = release_v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_sequence();
    int         pick;
    int         r;
    int         k;
    logic [7:0] code;
    pick = $urandom_range(99);
    if (pick < 35) begin
      host(srmc_pkg::MARK_HEAD);
      host(srmc_pkg::ROUTE_FRAME);
      host(srmc_pkg::MARK_HEAD);
      host(srmc_pkg::MARK_HEAD);
      k = $urandom_range(6, 1);
      repeat (k) begin
        r = $urandom_range(99);
        if (r < 70) code = 8'($urandom_range(CODE_COUNT - 1));
        else if (r < 80) code = srmc_pkg::MARK_SKIP;
        else if (r < 84) code = srmc_pkg::MARK_REPLAY;
        else code = 8'($urandom_range(255));
        host(code);
      end
      host(srmc_pkg::MARK_END);
    end else if (pick < 50) begin
      host(srmc_pkg::MARK_HEAD);
      host(srmc_pkg::ROUTE_FWD);
      k = $urandom_range(4, 1);
      repeat (k) host(8'($urandom_range(255)));
    end else if (pick < 65) begin
      host(srmc_pkg::MARK_HEAD);
      host(srmc_pkg::ROUTE_RAW);
      code = 8'($urandom_range(255));
      if (code == srmc_pkg::MARK_HEAD) code = 8'h00;
      host(code);
      host(8'($urandom_range(255)));
      host(8'($urandom_range(255)));
    end else if (pick < 75) begin
      send(srmc_pkg::OP_AUX, 8'($urandom_range(255)), 8'($urandom_range(255)),
           8'($urandom_range(255)), 1'b1);
    end else if (pick < 78) begin
      send(srmc_pkg::OP_START, 8'($urandom_range(255)), 8'($urandom_range(255)),
           8'($urandom_range(255)), 1'b1);
    end else if (pick < 88) begin
      host(srmc_pkg::MARK_HEAD);
      host(8'($urandom_range(255)));
    end else begin
      send(2'($urandom_range(3)), 8'($urandom_range(255)), 8'($urandom_range(255)),
           8'($urandom_range(255)), 1'b1);
    end
  endtask

  initial begin : receiver
    int holdoff_left;
    holdoff_left = 0;
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        holdoff_req  = 1'b0;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        out_stall <= 1'b1;
        holdoff_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: dest %0d, byte %0h, row %0h, col %0h",
               dest, out_byte, row_drive, col_drive);
        fails++;
      end else begin
        e = expected_results.pop_front();
        check_field("dest", 8'(e.dest), 8'(dest));
        check_field("out_byte", e.out_byte, out_byte);
        check_field("row_drive", e.row, row_drive);
        check_field("col_drive", e.col, col_drive);
        check_field("hold", e.hold, hold);
        check_field("last", 8'(e.last), 8'(last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int    target;
    step_t s;
    result_t x;
    reset_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      s = directed_steps[i];
      if (s.chk == CHK_ONE) begin
        x.dest     = s.dest;
        x.out_byte = s.out_byte;
        x.row      = s.row;
        x.col      = s.col;
        x.hold     = 8'h00;
        x.last     = 1'b1;
        expected_results.push_back(x);
      end
      send(s.op, s.data, s.sa, s.sb, s.chk == CHK_MODEL);
    end

    for (int pass = 0; pass < 4; pass++) begin
      settle();
      case (pass)
        0: write_registers(8'h00, 8'hFF);
        1: write_registers(8'hFF, 8'h00);
        default: write_registers(8'($urandom_range(255)), 8'($urandom_range(255)));
      endcase
      case (pass)
        0: begin idle_pct = 0;  stall_pct = 0;  holdoff_req = 1'b1; end
        1: begin idle_pct = 72; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      target = items_sent + ITEMS_PER_PASS;
      while (items_sent < target) random_sequence();
    end

    settle();
    if (fails == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
src/srmc_pkg.sv
src/srmc_front.sv
src/srmc_queue.sv
src/srmc_back.sv
src/serial_relay_matrix_controller.sv
src/srmc_checker.sv
tb/sv/testbench.sv
